### rtl/b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg: shared types and helpers for the base64 stream codec
// Alphabet mapping, state and result records used by the core and step logic.
// ----------------------------------------------------------------------------
package b64_pkg;

	localparam int unsigned MaxResults = 4;
	localparam int unsigned CountWidth = 3;

	localparam logic DirEncode = 1'b0;
	localparam logic DirDecode = 1'b1;

	localparam logic [7:0] PadChar = 8'h3D;  // '='

	// Codec state carried between items
	typedef struct packed {
		logic [23:0] group_bits;
		logic [1:0]  group_fill;
		logic        failed;
	} b64_state_t;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_message;
		logic       bad_code;
	} b64_result_t;

	// Map a sextet to its alphabet character
	function automatic logic [7:0] b64_encode_char(input logic [5:0] v);
		logic [7:0] w;
		begin
			w = {2'b00, v};
			if (v < 6'd26) begin
				b64_encode_char = 8'h41 + w;
			end else if (v < 6'd52) begin
				b64_encode_char = 8'h61 + w - 8'd26;
			end else if (v < 6'd62) begin
				b64_encode_char = 8'h30 + w - 8'd52;
			end else if (v == 6'd62) begin
				b64_encode_char = 8'h2B;
			end else begin
				b64_encode_char = 8'h2F;
			end
		end
	endfunction

	// Map a character to {valid, sextet}; pad counts as zero
	function automatic logic [6:0] b64_decode_char(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'h00;
			if (c >= 8'h41 && c <= 8'h5A) begin
				t = c - 8'h41;
				b64_decode_char = {1'b1, t[5:0]};
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				t = c - 8'h61 + 8'd26;
				b64_decode_char = {1'b1, t[5:0]};
			end else if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30 + 8'd52;
				b64_decode_char = {1'b1, t[5:0]};
			end else if (c == 8'h2B) begin
				b64_decode_char = {1'b1, 6'd62};
			end else if (c == 8'h2F) begin
				b64_decode_char = {1'b1, 6'd63};
			end else if (c == PadChar) begin
				b64_decode_char = {1'b1, 6'd0};
			end else begin
				b64_decode_char = {1'b0, t[5:0]};
			end
		end
	endfunction

endpackage

### rtl/b64_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_in_if: input item channel
// Valid/ready handshake carrying one byte or character and an end marker.
// ----------------------------------------------------------------------------
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_item;

	modport source (output valid, output data_byte, output last_item, input ready);
	modport sink (input valid, input data_byte, input last_item, output ready);
endinterface

### rtl/b64_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_out_if: result item channel
// Valid/ready handshake carrying one output byte with end and error flags.
// ----------------------------------------------------------------------------
interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_message;
	logic       bad_code;

	modport source (output valid, output out_byte, output end_of_message,
		output bad_code, input ready);
	modport sink (input valid, input out_byte, input end_of_message,
		input bad_code, output ready);
endinterface

### rtl/base64_stream_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_core: streaming base64 encoder / decoder
// Standard alphabet with pad; direction register selects encode or decode.
// ----------------------------------------------------------------------------
// Usage:
//   items   - input channel: data_byte (raw byte or character), last_item.
//   results - output channel: out_byte, end_of_message, bad_code.
//   direction_we / direction_wdata - write the mode (0 encode, 1 decode);
//     a write also clears the gathered group. Write only while idle.
// Timing:
//   An accepted item is registered, then processed combinationally into a
//   four-entry result buffer; its first result is valid once the buffer
//   has loaded it. The buffer sends one result per cycle while results.ready
//   is high and takes the next item only as its last result leaves.
//   With no results pending, items are taken back to back.
//   A new item is taken while earlier results are still waiting.
// Reset: arst_n clears the mode to encode, the group state and all queues.
// Stall: when results.ready is low the buffer holds; one more item waits in
//   the input register, then items.ready drops until the buffer drains.
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction_we,
	input  logic       direction_wdata,
	b64_in_if.sink     items,
	b64_out_if.source  results
);
	import b64_pkg::*;

	logic                  direction_q;
	b64_state_t            state_q;
	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  last_s1;
	logic [CountWidth-1:0] rem_q;
	b64_result_t           res_q [MaxResults];

	b64_state_t            state_nxt;
	logic [CountWidth-1:0] step_count;
	b64_result_t           step_res [MaxResults];
	logic                  out_pop;
	logic                  buf_free;
	logic                  take;

	assign out_pop  = results.valid && results.ready;
	assign buf_free = (rem_q == '0) || (rem_q == CountWidth'(1) && results.ready);
	assign take     = valid_s1 && buf_free;
	assign items.ready = !valid_s1 || take;

	b64_step u_step (
		.direction (direction_q),
		.state_cur (state_q),
		.data_byte (data_s1),
		.last_item (last_s1),
		.state_nxt (state_nxt),
		.res_count (step_count),
		.res       (step_res)
	);

	// Mode register and codec state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DirEncode;
			state_q     <= '0;
		end else if (direction_we) begin
			direction_q <= direction_wdata;
			state_q     <= '0;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	// Input register: hold an item until the buffer can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			data_s1 <= items.data_byte;
			last_s1 <= items.last_item;
		end
	end

	// Result count: load on take, count down on each sent result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (take) begin
			rem_q <= step_count;
		end else if (out_pop) begin
			rem_q <= rem_q - CountWidth'(1);
		end
	end

	// Result buffer: load all entries, shift toward the head on each send
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < MaxResults; i++) begin
				res_q[i] <= step_res[i];
			end
		end else if (out_pop) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

	assign results.valid          = (rem_q != '0);
	assign results.out_byte       = res_q[0].out_byte;
	assign results.end_of_message = res_q[0].end_of_message;
	assign results.bad_code       = res_q[0].bad_code;

	// Buffer never holds more than one item's results
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CountWidth'(MaxResults))
		else $error("result count above buffer depth");

	// Error flag is a decode-only condition
	a_enc_no_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(direction_q == DirEncode) |-> !state_q.failed)
		else $error("failed flag set in encode mode");

	// An error result carries a zero byte
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.bad_code) |-> (results.out_byte == 8'h00))
		else $error("error result with nonzero byte");

	// When the final result leaves, the group has already been cleared
	a_eom_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_pop && results.end_of_message) |->
			(state_q.group_fill == 2'd0 && !state_q.failed))
		else $error("group state not cleared at end of message");

	// A processed item only replaces the buffer once it has drained
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rem_q != '0) |-> (rem_q == CountWidth'(1) && out_pop))
		else $error("buffer overwritten with results pending");
endmodule

### rtl/b64_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_step: per-item codec logic
// Combines one item with the current state; gives next state and results.
// ----------------------------------------------------------------------------
module b64_step (
	input  logic                         direction,
	input  b64_pkg::b64_state_t          state_cur,
	input  logic [7:0]                   data_byte,
	input  logic                         last_item,
	output b64_pkg::b64_state_t          state_nxt,
	output logic [b64_pkg::CountWidth-1:0] res_count,
	output b64_pkg::b64_result_t         res [b64_pkg::MaxResults]
);
	import b64_pkg::*;

	logic [23:0] enc_gb;
	logic [23:0] enc_bits;
	logic [1:0]  enc_k;
	logic [6:0]  dec_v;
	logic [23:0] dec_gb;

	assign enc_gb = {state_cur.group_bits[15:0], data_byte};
	assign enc_k  = (state_cur.group_fill == 2'd3) ? 2'd3 : state_cur.group_fill + 2'd1;
	assign dec_v  = b64_decode_char(data_byte);
	assign dec_gb = {state_cur.group_bits[17:0], dec_v[5:0]};

	// Left-align a partial group for encoding
	always_comb begin
		unique case (enc_k)
			2'd1:    enc_bits = {enc_gb[7:0], 16'h0000};
			2'd2:    enc_bits = {enc_gb[15:0], 8'h00};
			default: enc_bits = enc_gb;
		endcase
	end

	// Next state and results
	always_comb begin
		state_nxt = state_cur;
		res_count = '0;
		for (int i = 0; i < MaxResults; i++) begin
			res[i] = '0;
		end

		if (direction == DirEncode) begin
			if (enc_k != 2'd3 && !last_item) begin
				// gather one more byte
				state_nxt.group_bits = enc_gb;
				state_nxt.group_fill = enc_k;
			end else begin
				// emit four characters, pad the tail
				for (int n = 0; n < MaxResults; n++) begin
					if (3'(n) <= {1'b0, enc_k}) begin
						res[n].out_byte = b64_encode_char(enc_bits[23 - 6*n -: 6]);
					end else begin
						res[n].out_byte = PadChar;
					end
					res[n].end_of_message = last_item && (n == MaxResults - 1);
				end
				res_count = CountWidth'(MaxResults);
				state_nxt.group_bits = '0;
				state_nxt.group_fill = '0;
				if (last_item) begin
					state_nxt.failed = 1'b0;
				end
			end
		end else begin
			if (state_cur.failed) begin
				// drop until the end of the message
				if (last_item) begin
					state_nxt = '0;
				end
			end else if (!dec_v[6]) begin
				// invalid character: one error result
				res[0].end_of_message = last_item;
				res[0].bad_code       = 1'b1;
				res_count             = CountWidth'(1);
				if (last_item) begin
					state_nxt = '0;
				end else begin
					state_nxt.failed = 1'b1;
				end
			end else if (state_cur.group_fill == 2'd3) begin
				// group complete: emit three bytes
				for (int n = 0; n < 3; n++) begin
					res[n].out_byte       = dec_gb[23 - 8*n -: 8];
					res[n].end_of_message = last_item && (n == 2);
				end
				res_count = CountWidth'(3);
				state_nxt = '0;
			end else if (last_item) begin
				// message ends inside a group
				res[0].end_of_message = 1'b1;
				res[0].bad_code       = 1'b1;
				res_count             = CountWidth'(1);
				state_nxt             = '0;
			end else begin
				state_nxt.group_bits = dec_gb;
				state_nxt.group_fill = state_cur.group_fill + 2'd1;
			end
		end
	end
endmodule
